>>> hw/rtl/bmtr_pkg.sv
package bmtr_pkg;

  // Screen geometry and text layout.
  localparam int SCREEN_HEIGHT = 240;
  localparam int SCREEN_WIDTH  = 400;
  localparam int CHAR_STEP_X   = 8;
  localparam int LINE_STEP_Y   = 10;

  // Field widths fixed by the item formats.
  localparam int CHAR_W  = 8;
  localparam int GROW_W  = 3;
  localparam int XORG_W  = 9;
  localparam int YORG_W  = 8;
  localparam int COLOR_W = 24;
  localparam int ADDR_W  = 19;
  localparam int LINE_W  = 10;
  localparam int COL_W   = 6;

  // Pixel coordinates reach start_x + 63 steps + 7, below 2048 with the 8-pixel step size.
  localparam int COORD_W = 11;

  localparam int FONT_DEPTH = 2048;
  localparam int FONT_AW    = CHAR_W + GROW_W;

  localparam logic [LINE_W-1:0] CY_MAX    = '1;
  localparam logic [COL_W-1:0]  COL_MAX   = '1;
  localparam logic [COL_W-1:0]  COL_WRAP  = COL_W'(2);

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // One screen column is SCREEN_HEIGHT pixels of three bytes each.
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(3 * SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] TOP_OFS  = ADDR_W'(3 * (SCREEN_HEIGHT - 1));
  localparam logic [ADDR_W-1:0] PIX_BYTES = ADDR_W'(3);

  typedef struct packed {
    logic               kind;
    logic [CHAR_W-1:0]  character;
    logic [GROW_W-1:0]  glyph_row;
    logic [7:0]         row_bits;
    logic               first_of_string;
    logic [XORG_W-1:0]  origin_x;
    logic [YORG_W-1:0]  origin_y;
    logic [COLOR_W-1:0] pixel_color;
  } char_word_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] write_color;
    logic               off_screen;
    logic [LINE_W-1:0]  line_y;
    logic               last;
  } pix_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;
    logic base;
    logic addr;
    logic step;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic draw;
    logic pix_last;
    logic out_busy;
  } dp_sts_t;

endpackage

>>> hw/rtl/bmtr_ram.sv
module bmtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/bmtr_ctrl.sv
module bmtr_ctrl
  import bmtr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    char_valid,
  output logic    char_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BASE = 2'd1;
  localparam logic [1:0] S_ADDR = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take = char_valid && !sts.out_busy && !rst;
        if (cmd.take && sts.draw) begin
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.step = !sts.out_busy;
        if (cmd.step && sts.pix_last) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // No word is taken while reset is held.
  assign char_stall = rst || (state != S_IDLE) || sts.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.take && sts.draw |=> state == S_BASE)
    else $error("drawn character did not start its setup");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && cmd.step && sts.pix_last |=> state == S_IDLE && !char_stall ||
      state == S_IDLE)
    else $error("glyph walk did not return to idle");

  a_no_step_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !cmd.take && !cmd.base && !cmd.addr)
    else $error("pixel step overlaps another command");

endmodule

>>> hw/rtl/bmtr_dp.sv
module bmtr_dp
  import bmtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  char_word_t char_word,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       pix_valid,
  input  logic       pix_stall,
  output pix_word_t  pix_word
);

  logic [XORG_W-1:0]  start_x;
  logic [LINE_W-1:0]  cursor_y;
  logic [COL_W-1:0]   column;
  logic [COLOR_W-1:0] text_color;
  logic [CHAR_W-1:0]  char_q;
  logic [COORD_W-1:0] base_x;
  logic [ADDR_W-1:0]  addr_row;
  logic [ADDR_W-1:0]  addr_cur;
  logic [5:0]         pix_cnt;

  logic [XORG_W-1:0]  sx_e;
  logic [LINE_W-1:0]  cy_e;
  logic [COL_W-1:0]   col_e;
  logic [COLOR_W-1:0] clr_e;
  logic [COORD_W-1:0] cy_step;
  logic [LINE_W-1:0]  cy_wrapped;
  logic [COORD_W-1:0] span;
  logic               wrap;
  logic [LINE_W-1:0]  cy_next;
  logic [COL_W-1:0]   col_next;
  logic               draw;

  logic [2:0]         pix_x;
  logic [2:0]         pix_y;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic               off;
  logic               bit_set;
  logic [ADDR_W-1:0]  addr0;
  pix_word_t          pix_next;
  pix_word_t          status_word;

  logic               ram_we;
  logic               ram_re;
  logic [FONT_AW-1:0] ram_raddr;
  logic [7:0]         row_data;

  // Layout of the incoming character against the current string state.
  always_comb begin
    sx_e  = char_word.first_of_string ? char_word.origin_x : start_x;
    cy_e  = char_word.first_of_string ? LINE_W'(char_word.origin_y) : cursor_y;
    col_e = char_word.first_of_string ? '0 : column;
    clr_e = char_word.first_of_string ? char_word.pixel_color : text_color;

    cy_step    = COORD_W'(cy_e) + COORD_W'(LINE_STEP_Y);
    cy_wrapped = (cy_step > COORD_W'(CY_MAX)) ? CY_MAX : cy_step[LINE_W-1:0];

    // The column fits when its right edge stays within the screen width and it is below COL_MAX.
    span = COORD_W'(sx_e) + (COORD_W'(col_e) + COORD_W'(1)) * COORD_W'(CHAR_STEP_X);
    wrap = (col_e == COL_MAX) || (span > COORD_W'(SCREEN_WIDTH));

    cy_next  = cursor_y;
    col_next = column;
    draw     = 1'b0;
    if (char_word.kind == KIND_DRAW) begin
      cy_next  = cy_e;
      col_next = col_e;
      priority if (char_word.character == CH_NUL) begin
        draw = 1'b0;
      end else if (char_word.character == CH_NEWLINE) begin
        cy_next  = cy_wrapped;
        col_next = '0;
      end else begin
        if (wrap) begin
          cy_next  = cy_wrapped;
          col_next = COL_WRAP;
        end
        draw = !(wrap && char_word.character == CH_SPACE);
      end
    end
  end

  assign pix_x = pix_cnt[2:0];
  assign pix_y = pix_cnt[5:3];

  always_comb begin
    px      = base_x + COORD_W'(pix_x);
    py      = COORD_W'(cursor_y) + COORD_W'(pix_y);
    off     = (px >= COORD_W'(SCREEN_WIDTH)) || (py >= COORD_W'(SCREEN_HEIGHT));
    bit_set = row_data[3'd7 - pix_x];

    pix_next.write_enable = bit_set && !off;
    pix_next.byte_address = off ? '0 : addr_cur;
    pix_next.write_color  = (bit_set && !off) ? text_color : '0;
    pix_next.off_screen   = bit_set && off;
    pix_next.line_y       = cursor_y;
    pix_next.last         = (pix_cnt == '1);

    status_word        = '0;
    status_word.line_y = cy_next;
    status_word.last   = 1'b1;
  end

  assign addr0 = ADDR_W'(base_x) * ROW_STEP + TOP_OFS - ADDR_W'(cursor_y) * PIX_BYTES;

  assign ram_we    = cmd.take && (char_word.kind == KIND_LOAD);
  assign ram_re    = (cmd.take && draw) || (cmd.step && pix_x == '1);
  assign ram_raddr = cmd.take ? {char_word.character, GROW_W'(0)}
                              : {char_q, pix_y + GROW_W'(1)};

  bmtr_ram #(
    .WIDTH(8),
    .DEPTH(FONT_DEPTH)
  ) u_font (
    .clk  (clk),
    .we   (ram_we),
    .waddr({char_word.character, char_word.glyph_row}),
    .wdata(char_word.row_bits),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(row_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      cursor_y   <= '0;
      column     <= '0;
      text_color <= '0;
      pix_valid  <= 1'b0;
    end else begin
      if (cmd.take) begin
        cursor_y <= cy_next;
        column   <= col_next;
        if (char_word.kind == KIND_DRAW) begin
          start_x    <= sx_e;
          text_color <= clr_e;
        end
      end
      if (cmd.base) begin
        column <= (column == COL_MAX) ? column : column + COL_W'(1);
      end
      if ((cmd.take && !draw) || cmd.step) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      char_q <= char_word.character;
      if (!draw) begin
        pix_word <= status_word;
      end
    end
    if (cmd.base) begin
      base_x  <= COORD_W'(start_x) + COORD_W'(column) * COORD_W'(CHAR_STEP_X);
      pix_cnt <= '0;
    end
    if (cmd.addr) begin
      addr_row <= addr0;
      addr_cur <= addr0;
    end
    if (cmd.step) begin
      pix_word <= pix_next;
      pix_cnt  <= pix_cnt + 6'd1;
      // Down one pixel row moves three bytes toward the start of the column.
      if (pix_x == '1) begin
        addr_row <= addr_row - PIX_BYTES;
        addr_cur <= addr_row - PIX_BYTES;
      end else begin
        addr_cur <= addr_cur + ROW_STEP;
      end
    end
  end

  assign sts.draw     = draw;
  assign sts.pix_last = (pix_cnt == '1);
  assign sts.out_busy = pix_valid && pix_stall;

  a_we_xor_off: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> !(pix_word.write_enable && pix_word.off_screen))
    else $error("pixel both written and flagged off screen");

  a_off_no_addr: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_word.off_screen |-> pix_word.byte_address == '0)
    else $error("off-screen pixel carries an address");

  a_load_status: assert property (@(posedge clk) disable iff (rst)
    cmd.take && char_word.kind == KIND_LOAD |=> pix_valid && pix_word.last)
    else $error("font load gave no status word");

endmodule

>>> hw/rtl/bitmap_text_rasterizer_top.sv
// Channel | Direction | Handshake               | Word
// char    | in        | char_valid / char_stall | char_word_t
// pix     | out       | pix_valid / pix_stall   | pix_word_t
//
// A font load, terminator, newline or skipped space gives one status word.
// A drawn character: accept, the S_BASE and S_ADDR setup states, then one pixel per cycle
// for 64 pixels unless pix stalls, via the single output register and a glyph row read per row.
// Reset clears the string state and the handshake; the font store holds garbage until loaded.
// A stall on pix holds the walk in place; char is stalled whenever the output word waits.
module bitmap_text_rasterizer_top
  import bmtr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_word_t char_word,
  output logic       pix_valid,
  input  logic       pix_stall,
  output pix_word_t  pix_word
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bmtr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmtr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .char_word(char_word),
    .cmd      (cmd),
    .sts      (sts),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_word (pix_word)
  );

endmodule
